// ===== design/gri_pkg.sv =====
package gri_pkg;

  // Default frame store size, handed to the top-level parameters.
  localparam int MaxRowsDefault = 256;
  localparam int MaxColsDefault = 256;

  // Width of a rotated-image dimension or position (up to 722 for a 511x511 source).
  localparam int DimW = 10;

  // Fixed-point format of the sine table.
  localparam int FracBits = 14;
  localparam int Q14Round = (1 << FracBits) - 1;

  // Entries of the queue between the front and the back.
  localparam int QueueDepth = 4;

  // Cycles the derived configuration takes to settle after a register write.
  localparam logic [1:0] SettleCycles = 2'd3;

  // APB address width and register indexes.
  localparam int ApbAddrW = 4;
  localparam logic [1:0] RegAngle = 2'd0;
  localparam logic [1:0] RegRows  = 2'd1;
  localparam logic [1:0] RegCols  = 2'd2;
  localparam logic [1:0] RegFill  = 2'd3;

  typedef enum logic [2:0] {
    ModePass  = 3'd0,
    ModeCw90  = 3'd1,
    ModeCw180 = 3'd2,
    ModeCw270 = 3'd3,
    ModeGen   = 3'd4
  } mode_e;

  // Configuration as the front and the back use it.
  typedef struct packed {
    mode_e              mode;
    logic [8:0]         h;
    logic [8:0]         w;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic [DimW-1:0]    oh;
    logic [DimW-1:0]    ow;
    logic signed [10:0] off;
    logic [7:0]         fill;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic busy;
  } ctl_t;

  typedef struct packed {
    logic            fetch;
    logic [7:0]      pix;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic            last;
  } queue_entry_t;

  localparam logic [14:0] SinQ14 [91] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997, 15'd2280,
    15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240, 15'd4516,
    15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402, 15'd6664,
    15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682,
    15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
    15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330,
    15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191,
    15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826,
    15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225,
    15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  // Angle reduced to 0..359 degrees.
  function automatic logic [8:0] mod360(input logic signed [10:0] a);
    logic signed [11:0] t;
    t = {a[10], a};
    if (t < 12'sd0) t = t + 12'sd720;
    if (t >= 12'sd360) t = t - 12'sd360;
    return t[8:0];
  endfunction

  // Sine in Q2.14 of an angle already reduced to 0..359 degrees.
  function automatic logic signed [15:0] sin_deg(input logic [8:0] m);
    logic [8:0]         idx;
    logic               neg;
    logic signed [15:0] v;
    if (m <= 9'd90) begin
      idx = m;
      neg = 1'b0;
    end else if (m <= 9'd180) begin
      idx = 9'd180 - m;
      neg = 1'b0;
    end else if (m <= 9'd270) begin
      idx = m - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - m;
      neg = 1'b1;
    end
    v = $signed({1'b0, SinQ14[idx[6:0]]});
    return neg ? -v : v;
  endfunction

endpackage

// ===== design/gri_in_if.sv =====
interface gri_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink (input valid, input kind, input pixel_in, output ready);
endinterface

// ===== design/gri_out_if.sv =====
interface gri_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [8:0] out_row;
  logic [8:0] out_col;
  logic [8:0] out_height;
  logic [8:0] out_width;
  logic       last;

  modport source (
    output valid, output pixel_out, output out_row, output out_col,
    output out_height, output out_width, output last, input ready
  );
  modport sink (
    input valid, input pixel_out, input out_row, input out_col,
    input out_height, input out_width, input last, output ready
  );
endinterface

// ===== design/grayscale_image_rotator.sv =====
// Nearest-neighbor grayscale rotator. A transaction with kind 0 loads one source pixel
// into the frame store in raster order; a transaction with kind 1 returns the next pixel of
// the rotated image in raster order, with its position, the rotated size and a last flag.
// Both kinds are accepted one per cycle while the four-entry queue between the front and
// the back has room and the input is not held off; a fetch result passes through the queue,
// two mapping stages, the address multiply and the registered store read, after which it
// sits in the output register, and the results stream out one per cycle while out_o.ready
// stays high. The frame store has a single access per cycle, so loads and fetches share
// that slot in order.
// After reset and after every register write the input is held off while the rotated size
// is recomputed; registers are to be written only while the block is idle.
// The frame store is not cleared, and fetching a pixel that was never loaded returns an
// undefined value. A register write restarts both the load and the fetch positions.
module grayscale_image_rotator
  import gri_pkg::*;
#(
  parameter int MaxRows = MaxRowsDefault,
  parameter int MaxCols = MaxColsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gri_in_if.sink              in_i,
  gri_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t         cfg;
  ctl_t         ctl;
  queue_entry_t push_entry;
  queue_entry_t pop_entry;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  gri_cfg #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .ctl_o   (ctl)
  );

  gri_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .ctl_i   (ctl),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  gri_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  gri_back #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== design/gri_ram.sv =====
module gri_ram #(
  parameter int Width = 8,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/gri_cfg.sv =====
module gri_cfg
  import gri_pkg::*;
#(
  parameter int MaxRows = MaxRowsDefault,
  parameter int MaxCols = MaxColsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o,
  output ctl_t                ctl_o
);

  logic signed [9:0] angle_q;
  logic [8:0]        rows_q;
  logic [8:0]        cols_q;
  logic [7:0]        fill_q;
  logic [1:0]        settle_q;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      rows_q  <= 9'd256;
      cols_q  <= 9'd256;
      fill_q  <= 8'd255;
    end else if (wr) begin
      case (paddr[3:2])
        RegAngle: angle_q <= $signed(pwdata[9:0]);
        RegRows:  rows_q  <= pwdata[8:0];
        RegCols:  cols_q  <= pwdata[8:0];
        RegFill:  fill_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAngle: prdata = {22'd0, angle_q};
      RegRows:  prdata = {23'd0, rows_q};
      RegCols:  prdata = {23'd0, cols_q};
      RegFill:  prdata = {24'd0, fill_q};
      default:  prdata = '0;
    endcase
  end

  // The derived sizes below are registered in stages after a write; input is held off until they settle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleCycles;
    end else if (wr) begin
      settle_q <= SettleCycles;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  assign ctl_o.clear = wr;
  assign ctl_o.busy  = (settle_q != 2'd0);

  // First stage: effective sizes, rotation mode, sine and cosine.
  logic signed [10:0] a_sin;
  logic signed [10:0] a_cos;
  logic [8:0]         m_sin;
  logic [8:0]         m_cos;
  logic [8:0]         h_eff;
  logic [8:0]         w_eff;
  mode_e              mode;

  always_comb begin
    a_sin = {angle_q[9], angle_q};
    a_cos = a_sin + 11'sd90;
    m_sin = mod360(a_sin);
    m_cos = mod360(a_cos);

    if (rows_q == 9'd0) h_eff = 9'd1;
    else if (int'(rows_q) > MaxRows) h_eff = 9'(MaxRows);
    else h_eff = rows_q;

    if (cols_q == 9'd0) w_eff = 9'd1;
    else if (int'(cols_q) > MaxCols) w_eff = 9'(MaxCols);
    else w_eff = cols_q;

    // Negative quarter turns leave the image as it is.
    if (m_sin == 9'd0) mode = ModePass;
    else if (m_sin == 9'd90) mode = (angle_q > 10'sd0) ? ModeCw90 : ModePass;
    else if (m_sin == 9'd180) mode = (angle_q > 10'sd0) ? ModeCw180 : ModePass;
    else if (m_sin == 9'd270) mode = (angle_q > 10'sd0) ? ModeCw270 : ModePass;
    else mode = ModeGen;
  end

  mode_e              d1_mode_q;
  logic [8:0]         d1_h_q;
  logic [8:0]         d1_w_q;
  logic signed [15:0] d1_sin_q;
  logic signed [15:0] d1_cos_q;

  always_ff @(posedge clk_i) begin
    d1_mode_q <= mode;
    d1_h_q    <= h_eff;
    d1_w_q    <= w_eff;
    d1_sin_q  <= sin_deg(m_sin);
    d1_cos_q  <= sin_deg(m_cos);
  end

  // Second stage: magnitudes times the source sizes.
  logic [14:0] abs_sin;
  logic [14:0] abs_cos;

  assign abs_sin = (d1_sin_q < 16'sd0) ? 15'(-d1_sin_q) : 15'(d1_sin_q);
  assign abs_cos = (d1_cos_q < 16'sd0) ? 15'(-d1_cos_q) : 15'(d1_cos_q);

  mode_e              d2_mode_q;
  logic [8:0]         d2_h_q;
  logic [8:0]         d2_w_q;
  logic signed [15:0] d2_sin_q;
  logic signed [15:0] d2_cos_q;
  logic [23:0]        d2_asw_q;
  logic [23:0]        d2_ach_q;
  logic [23:0]        d2_acw_q;
  logic [23:0]        d2_ash_q;

  always_ff @(posedge clk_i) begin
    d2_mode_q <= d1_mode_q;
    d2_h_q    <= d1_h_q;
    d2_w_q    <= d1_w_q;
    d2_sin_q  <= d1_sin_q;
    d2_cos_q  <= d1_cos_q;
    d2_asw_q  <= 24'(abs_sin) * 24'(d1_w_q);
    d2_ach_q  <= 24'(abs_cos) * 24'(d1_h_q);
    d2_acw_q  <= 24'(abs_cos) * 24'(d1_w_q);
    d2_ash_q  <= 24'(abs_sin) * 24'(d1_h_q);
  end

  // Third stage: rotated size and the column offset of the general mapping.
  logic [24:0]     sum_h;
  logic [24:0]     sum_w;
  logic [DimW-1:0] nh;
  logic [DimW-1:0] nw;
  logic [DimW-1:0] oh;
  logic [DimW-1:0] ow;

  always_comb begin
    sum_h = 25'(d2_asw_q) + 25'(d2_ach_q);
    sum_w = 25'(d2_acw_q) + 25'(d2_ash_q);
    nh    = DimW'(sum_h >> FracBits);
    nw    = DimW'(sum_w >> FracBits);
    if (nh == '0) nh = DimW'(1);
    if (nw == '0) nw = DimW'(1);
    case (d2_mode_q)
      ModeCw90, ModeCw270: begin
        oh = DimW'(d2_w_q);
        ow = DimW'(d2_h_q);
      end
      ModeGen: begin
        oh = nh;
        ow = nw;
      end
      default: begin
        oh = DimW'(d2_h_q);
        ow = DimW'(d2_w_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cfg_o.mode  <= d2_mode_q;
    cfg_o.h     <= d2_h_q;
    cfg_o.w     <= d2_w_q;
    cfg_o.sin_v <= d2_sin_q;
    cfg_o.cos_v <= d2_cos_q;
    cfg_o.oh    <= oh;
    cfg_o.ow    <= ow;
    cfg_o.off   <= $signed({1'b0, ow}) - $signed({2'b00, d2_w_q});
    cfg_o.fill  <= fill_q;
  end

  a_write_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> ctl_o.busy)
    else $error("input not held off after a register write");

endmodule

// ===== design/gri_front.sv =====
module gri_front
  import gri_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  gri_in_if.sink       in_i,
  input  cfg_t         cfg_i,
  input  ctl_t         ctl_i,
  input  logic         full_i,
  output logic         push_o,
  output queue_entry_t entry_o
);

  logic [DimW-1:0] emit_row_q, emit_row_d;
  logic [DimW-1:0] emit_col_q, emit_col_d;
  logic [8:0]      load_row_q, load_row_d;
  logic [8:0]      load_col_q, load_col_d;
  logic [DimW-1:0] fr;
  logic [DimW-1:0] fc;
  logic            last;

  assign in_i.ready = !full_i && !ctl_i.busy;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    // A position left over from a larger size restarts the frame.
    if (emit_row_q >= cfg_i.oh || emit_col_q >= cfg_i.ow) begin
      fr = '0;
      fc = '0;
    end else begin
      fr = emit_row_q;
      fc = emit_col_q;
    end
    last = (fr == cfg_i.oh - DimW'(1)) && (fc == cfg_i.ow - DimW'(1));

    emit_row_d = emit_row_q;
    emit_col_d = emit_col_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;

    if (push_o) begin
      if (in_i.kind) begin
        if (last) begin
          emit_row_d = '0;
          emit_col_d = '0;
        end else if (fc + DimW'(1) >= cfg_i.ow) begin
          emit_row_d = fr + DimW'(1);
          emit_col_d = '0;
        end else begin
          emit_row_d = fr;
          emit_col_d = fc + DimW'(1);
        end
      end else begin
        // Loads run through the source frame in raster order.
        if ({1'b0, load_col_q} + 10'd1 >= {1'b0, cfg_i.w}) begin
          load_col_d = '0;
          if ({1'b0, load_row_q} + 10'd1 >= {1'b0, cfg_i.h}) load_row_d = '0;
          else load_row_d = load_row_q + 9'd1;
        end else begin
          load_col_d = load_col_q + 9'd1;
        end
      end
    end

    if (ctl_i.clear) begin
      emit_row_d = '0;
      emit_col_d = '0;
      load_row_d = '0;
      load_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_row_q <= '0;
      emit_col_q <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
    end else begin
      emit_row_q <= emit_row_d;
      emit_col_q <= emit_col_d;
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
    end
  end

  always_comb begin
    entry_o.fetch = in_i.kind;
    entry_o.pix   = in_i.pixel_in;
    entry_o.row   = in_i.kind ? fr : DimW'(load_row_q);
    entry_o.col   = in_i.kind ? fc : DimW'(load_col_q);
    entry_o.last  = in_i.kind && last;
  end

  a_fetch_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.fetch |-> entry_o.row < cfg_i.oh && entry_o.col < cfg_i.ow)
    else $error("fetch position outside the rotated frame");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.last |=> emit_row_q == '0 && emit_col_q == '0)
    else $error("emit position not restarted after the last pixel");

endmodule

// ===== design/gri_fifo.sv =====
module gri_fifo
  import gri_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output queue_entry_t entry_o,
  output logic         empty_o
);

  localparam int PtrW = $clog2(QueueDepth);

  queue_entry_t    slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

endmodule

// ===== design/gri_back.sv =====
module gri_back
  import gri_pkg::*;
#(
  parameter int MaxRows = MaxRowsDefault,
  parameter int MaxCols = MaxColsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         empty_i,
  input  queue_entry_t entry_i,
  output logic         pop_o,
  gri_out_if.source    out_o
);

  localparam int Depth = MaxRows * MaxCols;
  localparam int AddrW = $clog2(Depth);
  localparam int LinW  = 18;

  logic adv;
  logic o_valid_q;

  // The whole pipeline moves together; it stops only when the output register is held.
  assign adv   = !o_valid_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  // Stage 1: quarter-turn source position, or the products of the general mapping.
  logic [DimW-1:0]    hm1;
  logic [DimW-1:0]    wm1;
  logic [DimW-1:0]    qr;
  logic [DimW-1:0]    qc;
  logic               gen;
  logic signed [10:0] xs11;
  logic signed [10:0] ys11;

  always_comb begin
    hm1  = DimW'(cfg_i.h) - DimW'(1);
    wm1  = DimW'(cfg_i.w) - DimW'(1);
    xs11 = $signed({1'b0, entry_i.row});
    ys11 = $signed({1'b0, entry_i.col});
    qr   = entry_i.row;
    qc   = entry_i.col;
    gen  = 1'b0;
    if (entry_i.fetch) begin
      case (cfg_i.mode)
        ModeCw90: begin
          qr = hm1 - entry_i.col;
          qc = entry_i.row;
        end
        ModeCw180: begin
          qr = hm1 - entry_i.row;
          qc = wm1 - entry_i.col;
        end
        ModeCw270: begin
          qr = entry_i.col;
          qc = wm1 - entry_i.row;
        end
        ModeGen: gen = 1'b1;
        default: ;
      endcase
    end
  end

  logic               s1_valid_q;
  logic               s1_fetch_q;
  logic [7:0]         s1_pix_q;
  logic               s1_last_q;
  logic [DimW-1:0]    s1_orow_q;
  logic [DimW-1:0]    s1_ocol_q;
  logic               s1_gen_q;
  logic [8:0]         s1_qr_q;
  logic [8:0]         s1_qc_q;
  logic signed [26:0] s1_pxs_q;
  logic signed [26:0] s1_pyc_q;
  logic signed [26:0] s1_pxc_q;
  logic signed [26:0] s1_pys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= !empty_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_fetch_q <= entry_i.fetch;
      s1_pix_q   <= entry_i.pix;
      s1_last_q  <= entry_i.last;
      s1_orow_q  <= entry_i.row;
      s1_ocol_q  <= entry_i.col;
      s1_gen_q   <= gen;
      s1_qr_q    <= qr[8:0];
      s1_qc_q    <= qc[8:0];
      s1_pxs_q   <= 27'(xs11) * 27'(cfg_i.sin_v);
      s1_pyc_q   <= 27'(ys11) * 27'(cfg_i.cos_v);
      s1_pxc_q   <= 27'(xs11) * 27'(cfg_i.cos_v);
      s1_pys_q   <= 27'(ys11) * 27'(cfg_i.sin_v);
    end
  end

  // Stage 2: inverse mapping, truncated toward zero, and the bounds check.
  logic signed [28:0] num_col;
  logic signed [28:0] num_row;
  logic signed [28:0] src_col;
  logic signed [28:0] src_row;
  logic               in_range;
  logic [8:0]         r2;
  logic [8:0]         c2;
  logic               fill2;

  always_comb begin
    num_col = 29'(s1_pxs_q) + 29'(s1_pyc_q) - (29'(cfg_i.off) <<< FracBits);
    num_row = 29'(s1_pxc_q) - 29'(s1_pys_q);
    src_col = (num_col < 29'sd0) ? (num_col + 29'(Q14Round)) >>> FracBits
                                 : num_col >>> FracBits;
    src_row = (num_row < 29'sd0) ? (num_row + 29'(Q14Round)) >>> FracBits
                                 : num_row >>> FracBits;
    in_range = !src_row[28] && (src_row < 29'(cfg_i.h)) &&
               !src_col[28] && (src_col < 29'(cfg_i.w));
    if (s1_gen_q) begin
      r2    = src_row[8:0];
      c2    = src_col[8:0];
      fill2 = !in_range;
    end else begin
      r2    = s1_qr_q;
      c2    = s1_qc_q;
      fill2 = 1'b0;
    end
  end

  logic            s2_valid_q;
  logic            s2_fetch_q;
  logic [7:0]      s2_pix_q;
  logic            s2_last_q;
  logic [DimW-1:0] s2_orow_q;
  logic [DimW-1:0] s2_ocol_q;
  logic            s2_fill_q;
  logic [8:0]      s2_r_q;
  logic [8:0]      s2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fetch_q <= s1_fetch_q;
      s2_pix_q   <= s1_pix_q;
      s2_last_q  <= s1_last_q;
      s2_orow_q  <= s1_orow_q;
      s2_ocol_q  <= s1_ocol_q;
      s2_fill_q  <= fill2;
      s2_r_q     <= r2;
      s2_c_q     <= c2;
    end
  end

  // Stage 3: linear store address.
  logic            s3_valid_q;
  logic            s3_fetch_q;
  logic [7:0]      s3_pix_q;
  logic            s3_last_q;
  logic [DimW-1:0] s3_orow_q;
  logic [DimW-1:0] s3_ocol_q;
  logic            s3_fill_q;
  logic [LinW-1:0] s3_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else if (adv) s3_valid_q <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_fetch_q <= s2_fetch_q;
      s3_pix_q   <= s2_pix_q;
      s3_last_q  <= s2_last_q;
      s3_orow_q  <= s2_orow_q;
      s3_ocol_q  <= s2_ocol_q;
      s3_fill_q  <= s2_fill_q;
      s3_lin_q   <= LinW'(s2_r_q) * LinW'(cfg_i.w) + LinW'(s2_c_q);
    end
  end

  // Stage 4: store access, a write for a load and a read for a fetch.
  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_rdata;

  assign ram_we   = adv && s3_valid_q && !s3_fetch_q;
  assign ram_re   = adv && s3_valid_q && s3_fetch_q;
  assign ram_addr = AddrW'(s3_lin_q);

  gri_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (s3_pix_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  logic            s4_valid_q;
  logic            s4_last_q;
  logic [DimW-1:0] s4_orow_q;
  logic [DimW-1:0] s4_ocol_q;
  logic            s4_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else if (adv) s4_valid_q <= s3_valid_q && s3_fetch_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_last_q <= s3_last_q;
      s4_orow_q <= s3_orow_q;
      s4_ocol_q <= s3_ocol_q;
      s4_fill_q <= s3_fill_q;
    end
  end

  // Output register.
  logic [7:0] o_pix_q;
  logic [8:0] o_row_q;
  logic [8:0] o_col_q;
  logic       o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_valid_q <= 1'b0;
    else if (adv) o_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_pix_q  <= s4_fill_q ? cfg_i.fill : ram_rdata;
      o_row_q  <= s4_orow_q[8:0];
      o_col_q  <= s4_ocol_q[8:0];
      o_last_q <= s4_last_q;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.pixel_out  = o_pix_q;
  assign out_o.out_row    = o_row_q;
  assign out_o.out_col    = o_col_q;
  assign out_o.out_height = cfg_i.oh[8:0];
  assign out_o.out_width  = cfg_i.ow[8:0];
  assign out_o.last       = o_last_q;

  // A pixel that takes the fill value carries an address that is never used.
  a_addr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_fill_q |-> int'(s3_lin_q) < Depth)
    else $error("store address beyond the frame store");

  a_fill_only_general: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_fill_q |-> s2_fetch_q && cfg_i.mode == ModeGen)
    else $error("fill value chosen outside the general mapping");

endmodule
